>>> rtl/nh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nh_pkg
// shared types, constants and helpers of the letter n-gram histogram
// ----------------------------------------------------------------------------
package nh_pkg;

   localparam int MAX_GRAM    = 4;
   localparam int STORE_DEPTH = 524288;
   localparam int COUNT_BITS  = 16;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int KEY_BITS    = 19;
   localparam int LETTER_BITS = 5;
   localparam int CMD_BITS    = 2;
   localparam int LEN_BITS    = 3;
   localparam int OUT_BITS    = 16;
   localparam int FILL_BITS   = $clog2(MAX_GRAM + 1);
   localparam int ALPHA       = 26;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LEN_BITS-1:0]   DEFAULT_LEN = LEN_BITS'(4);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
   localparam logic [OUT_BITS-1:0]   OUT_MAX     = {OUT_BITS{1'b1}};

   typedef enum logic [CMD_BITS-1:0] {
      CMD_START = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_INC,
      OP_READ
   } op_code_type;

   typedef struct packed {
      op_code_type            code;
      logic                   in_range;
      logic [ADDR_BITS-1:0]   addr;
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic sweeping;
   } back_status_type;

   // weight of base-26 digit idx
   function automatic logic [KEY_BITS-1:0] gram_weight(input int idx);
      int w;
      w = 1;
      for (int j = 0; j < MAX_GRAM; j++) begin
         if (j < idx) begin
            w = w * ALPHA;
         end
      end
      return KEY_BITS'(w);
   endfunction

   // clamp a stored count to the output width
   function automatic logic [OUT_BITS-1:0] sat_out(input logic [COUNT_BITS-1:0] c);
      logic [OUT_BITS-1:0] r;
      if (32'(c) > 32'(OUT_MAX)) begin
         r = OUT_MAX;
      end else begin
         r = OUT_BITS'(c);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/ngram_histogram_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ngram_histogram_top
// letter n-gram frequency counter with a 2^19-entry saturating histogram
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while the op queue has room and no clear
// sweep runs: letters, reads and starts enter a four-entry op queue and the
// histogram store performs one read-modify-write per cycle unless a held
// response stalls it, with the last write forwarded to the next read. A read's
// count passes the op queue, stage-A and response registers to rsp_valid; ops
// waiting ahead and a held response delay it. After reset, and after every
// start transaction, the store is cleared by a sweep of all 524288 entries,
// one entry per cycle through the memory write port; req_ready stays low during
// the sweep. gram_length may be written only while the block is idle.
module ngram_histogram_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [nh_pkg::CMD_BITS-1:0]     req_cmd,
   input  wire logic [nh_pkg::LETTER_BITS-1:0]  req_letter,
   input  wire logic [nh_pkg::KEY_BITS-1:0]     req_read_key,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [nh_pkg::OUT_BITS-1:0]          rsp_gram_count,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [nh_pkg::LEN_BITS-1:0]     csr_gram_length
);

   logic [nh_pkg::LEN_BITS-1:0] gram_length_ff;
   logic                        q_push;
   nh_pkg::op_type              q_push_op;
   logic                        q_pop;
   nh_pkg::op_type              q_head_op;
   nh_pkg::queue_status_type    q_status;
   nh_pkg::back_status_type     back_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gram_length_ff <= nh_pkg::DEFAULT_LEN;
      end else if (csr_valid && csr_ready) begin
         gram_length_ff <= csr_gram_length;
      end
   end

   nh_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_letter   (req_letter),
      .req_read_key (req_read_key),
      .gram_length  (gram_length_ff),
      .q_status     (q_status),
      .back_status  (back_status),
      .push         (q_push),
      .push_op      (q_push_op)
   );

   nh_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (q_push_op),
      .pop     (q_pop),
      .head_op (q_head_op),
      .status  (q_status)
   );

   nh_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .head_op        (q_head_op),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_gram_count (rsp_gram_count),
      .status         (back_status)
   );

`ifndef SYNTHESIS
   // no transaction accepted while the store is being cleared
   a_no_req_in_sweep : assert property (@(posedge clock) disable iff (reset)
      back_status.sweeping |-> !req_ready)
      else $error("request accepted during clear sweep");

   // queue never overflows or underflows
   a_queue_push : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("push into full op queue");

   a_queue_pop : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from empty op queue");

   // back end takes no op while sweeping
   a_no_pop_in_sweep : assert property (@(posedge clock) disable iff (reset)
      back_status.sweeping |-> !q_pop)
      else $error("op issued during clear sweep");
`endif

endmodule
`default_nettype wire

>>> rtl/nh_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nh_front
// accepts commands, keeps the sliding letter window and emits histogram ops
// ----------------------------------------------------------------------------
module nh_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [nh_pkg::CMD_BITS-1:0]     req_cmd,
   input  wire logic [nh_pkg::LETTER_BITS-1:0]  req_letter,
   input  wire logic [nh_pkg::KEY_BITS-1:0]     req_read_key,
   input  wire logic [nh_pkg::LEN_BITS-1:0]     gram_length,
   input  wire nh_pkg::queue_status_type        q_status,
   input  wire nh_pkg::back_status_type         back_status,
   output logic                                 push,
   output nh_pkg::op_type                       push_op
);

   logic [nh_pkg::LETTER_BITS-1:0] digits_ff [nh_pkg::MAX_GRAM];
   logic [nh_pkg::LETTER_BITS-1:0] digits_in [nh_pkg::MAX_GRAM];
   logic [nh_pkg::FILL_BITS-1:0]   fill_ff;
   logic [nh_pkg::FILL_BITS-1:0]   fill_in;
   logic [nh_pkg::FILL_BITS-1:0]   eff_len;
   logic [nh_pkg::KEY_BITS-1:0]    new_key;
   logic                           accept;
   logic                           letter_ok;
   logic                           count_ok;

   assign req_ready = !q_status.full && !back_status.sweeping;
   assign accept    = req_valid && req_ready;
   assign letter_ok = 32'(req_letter) < 32'(nh_pkg::ALPHA);

   always_comb begin
      if (gram_length == '0) begin
         eff_len = nh_pkg::FILL_BITS'(1);
      end else if (32'(gram_length) > 32'(nh_pkg::MAX_GRAM)) begin
         eff_len = nh_pkg::FILL_BITS'(nh_pkg::MAX_GRAM);
      end else begin
         eff_len = nh_pkg::FILL_BITS'(gram_length);
      end
   end

   // shift in the letter, keeping only the low eff_len digits
   always_comb begin
      digits_in[0] = req_letter;
      for (int i = 1; i < nh_pkg::MAX_GRAM; i++) begin
         digits_in[i] = (nh_pkg::FILL_BITS'(i) < eff_len) ? digits_ff[i-1] : '0;
      end
   end

   always_comb begin
      new_key = '0;
      for (int i = 0; i < nh_pkg::MAX_GRAM; i++) begin
         new_key = new_key
                 + nh_pkg::KEY_BITS'(digits_in[i]) * nh_pkg::gram_weight(i);
      end
   end

   assign fill_in  = (32'(fill_ff) < 32'(nh_pkg::MAX_GRAM)) ? fill_ff + 1'b1 : fill_ff;
   assign count_ok = (fill_in >= eff_len) && (32'(new_key) < 32'(nh_pkg::STORE_DEPTH));

   always_comb begin
      push             = 1'b0;
      push_op.code     = nh_pkg::OP_READ;
      push_op.in_range = 32'(req_read_key) < 32'(nh_pkg::STORE_DEPTH);
      push_op.addr     = req_read_key[nh_pkg::ADDR_BITS-1:0];
      case (req_cmd)
         nh_pkg::CMD_START: begin
            push         = accept;
            push_op.code = nh_pkg::OP_CLEAR;
         end
         nh_pkg::CMD_ADD: begin
            push             = accept && letter_ok && count_ok;
            push_op.code     = nh_pkg::OP_INC;
            push_op.in_range = 1'b1;
            push_op.addr     = new_key[nh_pkg::ADDR_BITS-1:0];
         end
         nh_pkg::CMD_READ: begin
            push = accept;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         for (int i = 0; i < nh_pkg::MAX_GRAM; i++) begin
            digits_ff[i] <= '0;
         end
      end else if (accept) begin
         if (req_cmd == nh_pkg::CMD_START) begin
            fill_ff <= '0;
            for (int i = 0; i < nh_pkg::MAX_GRAM; i++) begin
               digits_ff[i] <= '0;
            end
         end else if (req_cmd == nh_pkg::CMD_ADD && letter_ok) begin
            fill_ff <= fill_in;
            for (int i = 0; i < nh_pkg::MAX_GRAM; i++) begin
               digits_ff[i] <= digits_in[i];
            end
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/nh_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nh_queue
// short op queue between the front and the histogram back end
// ----------------------------------------------------------------------------
module nh_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire nh_pkg::op_type           push_op,
   input  wire logic                     pop,
   output nh_pkg::op_type                head_op,
   output nh_pkg::queue_status_type      status
);

   nh_pkg::op_type                entries_ff [nh_pkg::QUEUE_DEPTH];
   logic [nh_pkg::QPTR_BITS-1:0]  wr_ptr_ff;
   logic [nh_pkg::QPTR_BITS-1:0]  rd_ptr_ff;
   logic [nh_pkg::QCNT_BITS-1:0]  count_ff;

   assign head_op      = entries_ff[rd_ptr_ff];
   assign status.full  = count_ff == nh_pkg::QCNT_BITS'(nh_pkg::QUEUE_DEPTH);
   assign status.empty = count_ff == '0;

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/nh_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nh_back
// histogram store: read-modify-write with forwarding, reads and clear sweep
// ----------------------------------------------------------------------------
module nh_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire nh_pkg::queue_status_type      q_status,
   input  wire nh_pkg::op_type                head_op,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [nh_pkg::OUT_BITS-1:0]        rsp_gram_count,
   output nh_pkg::back_status_type            status
);

   logic [nh_pkg::COUNT_BITS-1:0] mem [nh_pkg::STORE_DEPTH];

   logic                          a_valid_ff;
   nh_pkg::op_type                a_op_ff;
   logic [nh_pkg::COUNT_BITS-1:0] rd_data_ff;
   logic                          fwd_valid_ff;
   logic [nh_pkg::ADDR_BITS-1:0]  fwd_addr_ff;
   logic [nh_pkg::COUNT_BITS-1:0] fwd_data_ff;
   logic                          sweep_ff;
   logic [nh_pkg::ADDR_BITS-1:0]  sweep_addr_ff;
   logic                          rsp_valid_ff;
   logic [nh_pkg::OUT_BITS-1:0]   rsp_count_ff;

   logic [nh_pkg::COUNT_BITS-1:0] cur_data;
   logic [nh_pkg::COUNT_BITS-1:0] inc_data;
   logic                          a_read;
   logic                          a_inc;
   logic                          a_clear;
   logic                          a_adv;
   logic                          wr_en;
   logic [nh_pkg::ADDR_BITS-1:0]  wr_addr;
   logic [nh_pkg::COUNT_BITS-1:0] wr_data;

   assign cur_data = (fwd_valid_ff && fwd_addr_ff == a_op_ff.addr) ? fwd_data_ff : rd_data_ff;
   assign inc_data = (cur_data == nh_pkg::COUNT_MAX) ? cur_data : cur_data + 1'b1;

   assign a_read  = a_valid_ff && a_op_ff.code == nh_pkg::OP_READ;
   assign a_inc   = a_valid_ff && a_op_ff.code == nh_pkg::OP_INC;
   assign a_clear = a_valid_ff && a_op_ff.code == nh_pkg::OP_CLEAR;
   assign a_adv   = !(a_read && rsp_valid_ff && !rsp_ready);
   assign pop     = a_adv && !q_status.empty && !sweep_ff && !a_clear;

   assign wr_en   = sweep_ff || a_inc;
   assign wr_addr = sweep_ff ? sweep_addr_ff : a_op_ff.addr;
   assign wr_data = sweep_ff ? '0 : inc_data;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_gram_count  = rsp_count_ff;
   assign status.sweeping = sweep_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (pop) begin
         rd_data_ff <= mem[head_op.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         a_op_ff <= head_op;
      end
      if (a_adv) begin
         fwd_addr_ff <= a_op_ff.addr;
         fwd_data_ff <= inc_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         sweep_ff      <= 1'b1;
         sweep_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (a_adv) begin
            a_valid_ff   <= pop;
            fwd_valid_ff <= a_inc;
         end
         // clear sweep, one entry per cycle
         if (sweep_ff) begin
            sweep_addr_ff <= sweep_addr_ff + 1'b1;
            if (sweep_addr_ff == nh_pkg::ADDR_BITS'(nh_pkg::STORE_DEPTH - 1)) begin
               sweep_ff <= 1'b0;
            end
         end else if (a_clear) begin
            sweep_ff      <= 1'b1;
            sweep_addr_ff <= '0;
         end
         if (a_read && a_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_read && a_adv) begin
         rsp_count_ff <= a_op_ff.in_range ? nh_pkg::sat_out(cur_data) : '0;
      end
   end

endmodule
`default_nettype wire
